[hw/rtl/arwc_pkg.sv]
// Shared types for the anti-replay window checker.
// No dependencies; imported by anti_replay_window_check_core.
package arwc_pkg;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_ROLL,
      ST_DONE
   } arwc_state_type;

endpackage

[hw/rtl/anti_replay_window_check_core.sv]
// Anti-replay sliding window checker: left edge plus a seen-bit window.
// Depends on arwc_pkg for the sequencer state type.
//
//   channel | ports                                             | direction
//   --------+---------------------------------------------------+----------
//   req     | req_valid, req_stall, req_partial_iv              | in
//   rsp     | rsp_valid, rsp_stall, rsp_first_use, rsp_edge_now | out
//
// An item is taken in ST_IDLE and checked in ST_CHECK; a jump past the window
// returns to ST_CHECK, through ST_ROLL when the new edge was already seen, and a
// number at the edge rolls it in ST_ROLL. The result register loads from ST_DONE.
// The roll moves the edge one position per cycle through the shared window shifter.
// The next request beat can be taken in the cycle after the result register loads.
// A jump past the window is applied in ST_CHECK by the same shifter.
// Reset clears the edge, the window and the result valid flag.
// req_stall is high while an item is in work; a stalled result beat holds the
// block in its last step, and no new request beat is taken meanwhile.
module anti_replay_window_check_core
   import arwc_pkg::*;
#(
   parameter int WINDOW_SIZE = 32,
   parameter int SEQ_WIDTH   = 40
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [SEQ_WIDTH-1:0] req_partial_iv,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_first_use,
   output logic [SEQ_WIDTH:0]   rsp_edge_now
);

   localparam int EW = SEQ_WIDTH + 1;
   localparam int AW = $clog2(WINDOW_SIZE + 1);
   localparam int IW = $clog2(WINDOW_SIZE);
   localparam logic [EW:0]   WIN_DIFF = (EW + 1)'(WINDOW_SIZE);
   localparam logic [EW-1:0] WIN_EDGE = EW'(WINDOW_SIZE);
   localparam logic [AW-1:0] WIN_AMT  = AW'(WINDOW_SIZE);

   arwc_state_type         state_ff, state_in;
   logic [EW-1:0]          num_ff, num_in;
   logic [EW-1:0]          edge_ff, edge_in;
   logic [WINDOW_SIZE-1:0] win_ff, win_in;
   logic                   first_ff, first_in;
   logic                   fin_ff, fin_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_first_use_ff;
   logic [EW-1:0]          rsp_edge_now_ff;

   logic [EW:0]            diff;
   logic [EW:0]            over_w;
   logic                   is_neg;
   logic                   is_zero;
   logic                   is_jump;
   logic                   is_big;
   logic [AW-1:0]          shift_amt;
   logic [WINDOW_SIZE:0]   shift_res;
   logic [AW-1:0]          idx_full;
   logic [IW-1:0]          bit_idx;
   logic                   rsp_load;

   // Distance of the number from the edge, and how far a jump overshoots the window.
   assign diff    = {1'b0, num_ff} - {1'b0, edge_ff};
   assign over_w  = diff - WIN_DIFF;
   assign is_neg  = diff[EW];
   assign is_zero = (diff == '0);
   assign is_jump = !is_neg && (diff > WIN_DIFF);
   assign is_big  = (over_w > WIN_DIFF);

   // Shared window shifter. The top bit is the last bit shifted out, which tells
   // whether the new edge was already seen.
   assign shift_amt = (state_ff == ST_ROLL) ? AW'(1) : over_w[AW-1:0];
   assign shift_res = {1'b0, win_ff} << shift_amt;

   assign idx_full = WIN_AMT - diff[AW-1:0];
   assign bit_idx  = idx_full[IW-1:0];

   assign rsp_load = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (is_jump) begin
               if (!is_big && shift_res[WINDOW_SIZE]) state_in = ST_ROLL;
               else state_in = ST_CHECK;
            end else if (is_neg) begin
               state_in = ST_DONE;
            end else if (is_zero) begin
               state_in = ST_ROLL;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_ROLL: begin
            if (!shift_res[WINDOW_SIZE]) state_in = fin_ff ? ST_DONE : ST_CHECK;
         end
         ST_DONE: begin
            if (rsp_load) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      num_in   = num_ff;
      edge_in  = edge_ff;
      win_in   = win_ff;
      first_in = first_ff;
      fin_in   = fin_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               num_in = {1'b0, req_partial_iv};
               fin_in = 1'b0;
            end
         end
         ST_CHECK: begin
            if (is_jump) begin
               // The edge lands exactly one window below the number.
               edge_in = num_ff - WIN_EDGE;
               win_in  = is_big ? '0 : shift_res[WINDOW_SIZE-1:0];
            end else if (is_neg) begin
               first_in = 1'b0;
            end else if (is_zero) begin
               first_in = 1'b1;
               fin_in   = 1'b1;
            end else begin
               first_in = !win_ff[bit_idx];
               win_in   = win_ff | (WINDOW_SIZE'(1) << bit_idx);
            end
         end
         ST_ROLL: begin
            edge_in = edge_ff + EW'(1);
            win_in  = shift_res[WINDOW_SIZE-1:0];
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      if (rsp_load) rsp_valid_in = 1'b1;
      else rsp_valid_in = rsp_valid_ff && rsp_stall;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         edge_ff      <= '0;
         win_ff       <= '0;
         fin_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         edge_ff      <= edge_in;
         win_ff       <= win_in;
         fin_ff       <= fin_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff   <= num_in;
      first_ff <= first_in;
      if (rsp_load) begin
         rsp_first_use_ff <= first_ff;
         rsp_edge_now_ff  <= edge_ff;
      end
   end

   assign req_stall     = (state_ff != ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_first_use = rsp_first_use_ff;
   assign rsp_edge_now  = rsp_edge_now_ff;

endmodule

[tb/tb.sv]
// Testbench for anti_replay_window_check_core: random and directed sequence numbers,
// each result beat checked against a predicted replay verdict and left edge.
// Depends only on the RTL of the block; holds its own window predictor.

class replay_sb_type;
   typedef struct packed {
      logic        first_use;
      logic [40:0] edge_now;
   } verdict_type;

   logic [40:0] left_pos;
   logic [31:0] seen_mask;
   verdict_type verdict_q[$];
   int          mismatches;

   function new();
      left_pos   = '0;
      seen_mask  = '0;
      mismatches = 0;
   endfunction

   // The edge always moves once, then keeps going while the bit shifted out was seen.
   function void roll_left_pos();
      logic was_seen;
      was_seen = 1'b1;
      while (was_seen) begin
         was_seen  = seen_mask[31];
         seen_mask = seen_mask << 1;
         left_pos  = left_pos + 41'd1;
      end
   endfunction

   function void slide_window(logic [40:0] steps);
      logic carry;
      int   pos;
      left_pos = left_pos + steps;
      if (steps > 41'd32) begin
         seen_mask = '0;
      end else begin
         pos       = 32 - int'(steps);
         carry     = seen_mask[pos];
         seen_mask = seen_mask << steps;
         if (carry) roll_left_pos();
      end
   endfunction

   function void note_seq_num(logic [39:0] seq_num);
      logic [40:0] num;
      logic [40:0] gap;
      int          pos;
      verdict_type want;
      num = {1'b0, seq_num};
      if (num > left_pos && num - left_pos > 41'd32) slide_window(num - left_pos - 41'd32);
      if (num < left_pos) begin
         want.first_use = 1'b0;
      end else if (num == left_pos) begin
         want.first_use = 1'b1;
         roll_left_pos();
      end else begin
         gap             = num - left_pos;
         pos             = 32 - int'(gap);
         want.first_use  = ~seen_mask[pos];
         seen_mask[pos]  = 1'b1;
      end
      want.edge_now = left_pos;
      verdict_q.push_back(want);
   endfunction

   function void check_verdict(logic first_use, logic [40:0] edge_now);
      verdict_type want;
      if (verdict_q.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("unexpected result beat: first_use %0b edge_now %0d",
                     first_use, edge_now);
         return;
      end
      want = verdict_q.pop_front();
      if (want.first_use !== first_use || want.edge_now !== edge_now) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch: first_use exp %0b got %0b, edge_now exp %0d got %0d",
                     want.first_use, first_use, want.edge_now, edge_now);
      end
   endfunction
endclass

module tb;
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic [39:0] req_partial_iv = '0;
   logic        rsp_stall = 1'b0;
   logic        req_stall;
   logic        rsp_valid;
   logic        rsp_first_use;
   logic [40:0] rsp_edge_now;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;

   replay_sb_type replay_sb = new();

   always #10 clock = ~clock;

   anti_replay_window_check_core dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_partial_iv (req_partial_iv),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_first_use  (rsp_first_use),
      .rsp_edge_now   (rsp_edge_now)
   );

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && !rsp_stall)
         replay_sb.check_verdict(rsp_first_use, rsp_edge_now);
   end

   task automatic send_seq_num(input logic [39:0] seq_num);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_partial_iv <= seq_num;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      replay_sb.note_seq_num(seq_num);
   endtask

   // Holds the request side quiet until every predicted result has been seen, or the wait limit runs out.
   task automatic wait_for_results(input int max_cycles);
      int waited;
      waited = 0;
      req_valid <= 1'b0;
      while (replay_sb.verdict_q.size() != 0 && waited < max_cycles) begin
         @(posedge clock);
         waited++;
      end
   endtask

   function automatic logic [39:0] near_edge(int offset);
      logic [40:0] base;
      base = replay_sb.left_pos;
      if (offset < 0) begin
         if (base < 41'(-offset)) return '0;
         return 40'(base - 41'(-offset));
      end
      return 40'(base + 41'(offset));
   endfunction

   // Mostly numbers around the window so the edge rolls, with replays, jumps and noise.
   function automatic logic [39:0] pick_seq_num();
      logic [40:0] base;
      logic [40:0] num;
      logic [63:0] noise;
      int          r;
      base  = replay_sb.left_pos;
      noise = {$urandom, $urandom};
      r     = $urandom_range(99);
      if (r < 68) begin
         num = base + 41'($urandom_range(34));
      end else if (r < 80) begin
         if (base > 41'd40) num = base - 41'($urandom_range(40, 1));
         else num = 41'($urandom_range(int'(base)));
      end else if (r < 92) begin
         num = base + 41'($urandom_range(70, 33));
      end else if (r < 98) begin
         num = base + 41'($urandom_range(1 << 20, 71));
      end else begin
         num = {1'b0, noise[39:0]};
      end
      if (num[40]) num = {1'b0, noise[39:0]};
      return num[39:0];
   endfunction

   initial begin
      int          opening[22];
      int          fill_order[31];
      int          j;
      int          tmp;
      logic [39:0] top;

      opening = '{0, -1, 2, 2, 1, 0, 32, 31, 33, 0, -5, 63, 64, 65, 1,
                  1000, 0, 40, -2000, 5000000, 0, 32};

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (opening[i]) send_seq_num(near_edge(opening[i]));
      wait_for_results(5000);

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin send_idle_pct = 20; recv_idle_pct = 57; end
            1: begin send_idle_pct = 57; recv_idle_pct = 20; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         repeat (300) send_seq_num(pick_seq_num());
         wait_for_results(5000);
      end

      // Fill the last window below the top of the range out of order, so the
      // final roll carries the edge to its largest value.
      send_idle_pct = 20;
      recv_idle_pct = 20;
      top = '1;
      for (int i = 0; i < 31; i++) fill_order[i] = i + 1;
      for (int i = 30; i > 0; i--) begin
         j             = $urandom_range(i);
         tmp           = fill_order[i];
         fill_order[i] = fill_order[j];
         fill_order[j] = tmp;
      end
      send_seq_num(top);
      foreach (fill_order[i]) send_seq_num(top - 40'd32 + 40'(fill_order[i]));
      send_seq_num(top - 40'd32);
      send_seq_num(top);
      send_seq_num('0);

      wait_for_results(20000);
      repeat (40) @(posedge clock);
      if (replay_sb.verdict_q.size() != 0) begin
         $display("%0d expected results never arrived", replay_sb.verdict_q.size());
         replay_sb.mismatches++;
      end
      if (replay_sb.mismatches == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

   initial begin
      #10_000_000;
      $display("FAILURE");
      $finish;
   end
endmodule

[anti_replay_window_check_core.f]
hw/rtl/arwc_pkg.sv
hw/rtl/anti_replay_window_check_core.sv
tb/tb.sv
